// ===== rtl/core/dttm_pkg.sv =====
// Shared types, constants and helper functions of the duration text parser.
package dttm_pkg;

  localparam int FRAC_DIGITS = 9;

  localparam int WHOLE_W = 54;
  localparam logic [WHOLE_W-1:0] WHOLE_CAP = '1;
  localparam int HALF_W = WHOLE_W / 2;
  localparam logic [63:0] SAT_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam int Q_W = 10;     // thousandths from the first three fraction digits
  localparam int K_W = 17;     // seconds per unit
  localparam int M_W = 27;     // milliseconds per unit
  localparam int Y_W = 17;     // sub-millisecond fraction term
  localparam int C_W = 50;     // reciprocal constant
  localparam int C_LO_W = 25;

  typedef enum logic [1:0] {
    FAM_SEC,
    FAM_MIN,
    FAM_HOUR,
    FAM_DAY
  } fam_t;

  typedef struct packed {
    logic valid;
    logic commit;
    logic done;
    logic ok;
    logic neg;
    fam_t fam;
  } tok_ctl_t;

  function automatic logic [39:0] pow10(input logic [3:0] n);
    case (n)
      4'd0:    pow10 = 40'd1;
      4'd1:    pow10 = 40'd10;
      4'd2:    pow10 = 40'd100;
      4'd3:    pow10 = 40'd1000;
      4'd4:    pow10 = 40'd10000;
      4'd5:    pow10 = 40'd100000;
      4'd6:    pow10 = 40'd1000000;
      4'd7:    pow10 = 40'd10000000;
      4'd8:    pow10 = 40'd100000000;
      4'd9:    pow10 = 40'd1000000000;
      4'd10:   pow10 = 40'd10000000000;
      4'd11:   pow10 = 40'd100000000000;
      4'd12:   pow10 = 40'd1000000000000;
      default: pow10 = 40'd0;
    endcase
  endfunction

  // divisor of the tail digits (fourth fraction digit onward)
  function automatic logic [39:0] tail_div(input int fd);
    tail_div = (fd > 3) ? pow10(4'(fd - 3)) : 40'd1;
  endfunction

  function automatic int tail_width(input int fd);
    int w;
    w = $clog2(tail_div(fd));
    tail_width = (w < 1) ? 1 : w;
  endfunction

  function automatic int magic_shift(input int fd);
    magic_shift = 2 * $clog2(tail_div(fd)) + 1;
  endfunction

  // ceil-like reciprocal: floor(k * 2^S / D) + 1, by bitwise long division
  function automatic logic [C_W-1:0] magic_c(input int k, input int fd);
    logic [127:0] num;
    logic [127:0] quo;
    logic [127:0] rem;
    logic [127:0] dv;
    num = 128'(k) << magic_shift(fd);
    dv = 128'(tail_div(fd));
    quo = '0;
    rem = '0;
    for (int i = 127; i >= 0; i--) begin
      rem = {rem[126:0], num[i]};
      if (rem >= dv) begin
        rem = rem - dv;
        quo[i] = 1'b1;
      end
    end
    magic_c = C_W'(quo + 128'd1);
  endfunction

  function automatic logic [K_W-1:0] unit_sec(input fam_t f);
    case (f)
      FAM_SEC:  unit_sec = K_W'(1);
      FAM_MIN:  unit_sec = K_W'(60);
      FAM_HOUR: unit_sec = K_W'(3600);
      FAM_DAY:  unit_sec = K_W'(86400);
      default:  unit_sec = K_W'(1);
    endcase
  endfunction

  function automatic logic [M_W-1:0] unit_ms(input fam_t f);
    unit_ms = M_W'(unit_sec(f) * 27'd1000);
  endfunction

endpackage

// ===== rtl/core/dttm_scan.sv =====
// Character scanner: grammar state machine, digit accumulation, part tokens.
module dttm_scan
  import dttm_pkg::*;
#(
  parameter int FracDigits = FRAC_DIGITS,
  parameter int RW = tail_width(FRAC_DIGITS)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_valid,
  input  logic [7:0]          in_char_code,
  input  logic                in_last_char,
  output tok_ctl_t            tok_ctl_r,
  output logic [WHOLE_W-1:0]  tok_whole_r,
  output logic [Q_W-1:0]      tok_q_r,
  output logic [RW-1:0]       tok_tail_r
);

  typedef enum logic [2:0] {
    PH_LEAD, PH_SIGNED, PH_WHOLE, PH_DOT, PH_FRAC, PH_GAP, PH_UNIT, PH_SEP
  } phase_t;

  phase_t             phase_r, phase_nxt;
  fam_t               fam_r, fam_nxt;
  logic [2:0]         ucnt_r, ucnt_nxt;
  logic               neg_r, neg_nxt;
  logic               err_r, err_nxt;
  logic [WHOLE_W-1:0] whole_r, whole_nxt;
  logic [Q_W-1:0]     q_r, q_nxt;
  logic [RW-1:0]      tail_r, tail_nxt;
  logic [3:0]         cnt_r, cnt_nxt;
  tok_ctl_t           tok_ctl_nxt;

  logic               take;
  logic               is_ws, is_dig, is_let;
  logic [7:0]         lc;
  logic [3:0]         dig;
  logic [WHOLE_W+3:0] w10;
  logic               commit_feed;
  logic               ok_end;
  logic [3:0]         widx;

  function automatic logic [7:0] unit_char(input fam_t f, input logic [2:0] n);
    logic [7:0] ch;
    ch = 8'h00;
    case (f)
      FAM_SEC: begin
        case (n)
          3'd1: ch = "e"; 3'd2: ch = "c"; 3'd3: ch = "o";
          3'd4: ch = "n"; 3'd5: ch = "d"; 3'd6: ch = "s";
          default: ch = 8'h00;
        endcase
      end
      FAM_MIN: begin
        case (n)
          3'd1: ch = "i"; 3'd2: ch = "n"; 3'd3: ch = "u";
          3'd4: ch = "t"; 3'd5: ch = "e"; 3'd6: ch = "s";
          default: ch = 8'h00;
        endcase
      end
      FAM_HOUR: begin
        case (n)
          3'd1: ch = "o"; 3'd2: ch = "u"; 3'd3: ch = "r"; 3'd4: ch = "s";
          default: ch = 8'h00;
        endcase
      end
      default: begin
        case (n)
          3'd1: ch = "a"; 3'd2: ch = "y"; 3'd3: ch = "s";
          default: ch = 8'h00;
        endcase
      end
    endcase
    unit_char = ch;
  endfunction

  // length of the full unit word
  function automatic logic [2:0] unit_len(input fam_t f);
    case (f)
      FAM_SEC, FAM_MIN: unit_len = 3'd7;
      FAM_HOUR:         unit_len = 3'd5;
      default:          unit_len = 3'd4;
    endcase
  endfunction

  // n == 0 encodes the short plurals secs / mins
  function automatic logic accepts(input fam_t f, input logic [2:0] n);
    logic a;
    if (n == 3'd0) a = (f == FAM_SEC) || (f == FAM_MIN);
    else if (n == 3'd1) a = 1'b1;
    else if ((f == FAM_SEC) || (f == FAM_MIN)) a = (n == 3'd3) || (n == 3'd6) || (n == 3'd7);
    else if (f == FAM_HOUR) a = (n == 3'd4) || (n == 3'd5);
    else a = (n == 3'd3) || (n == 3'd4);
    accepts = a;
  endfunction

  assign take   = in_valid && adv;
  assign is_ws  = (in_char_code == 8'd32) || (in_char_code inside {[8'd9:8'd13]});
  assign is_dig = in_char_code inside {["0":"9"]};
  assign is_let = (in_char_code inside {["a":"z"]}) || (in_char_code inside {["A":"Z"]});
  assign lc     = in_char_code | 8'h20;
  assign dig    = in_char_code[3:0];
  assign w10    = ({4'b0, whole_r} << 3) + ({4'b0, whole_r} << 1) + (WHOLE_W+4)'(dig);
  assign widx   = 4'(FracDigits - 1) - cnt_r;

  always_comb begin
    logic unit_ok;
    phase_nxt   = phase_r;
    fam_nxt     = fam_r;
    ucnt_nxt    = ucnt_r;
    neg_nxt     = neg_r;
    err_nxt     = err_r;
    whole_nxt   = whole_r;
    q_nxt       = q_r;
    tail_nxt    = tail_r;
    cnt_nxt     = cnt_r;
    commit_feed = 1'b0;
    unit_ok     = 1'b0;

    if (!err_r) begin
      case (phase_r)
        PH_LEAD, PH_SIGNED, PH_SEP: begin
          if (is_ws) begin
            phase_nxt = phase_r;
          end else if ((phase_r == PH_LEAD) && (in_char_code == "+" || in_char_code == "-")) begin
            neg_nxt   = (in_char_code == "-");
            phase_nxt = PH_SIGNED;
          end else if (is_dig) begin
            whole_nxt = WHOLE_W'(dig);
            q_nxt     = '0;
            tail_nxt  = '0;
            cnt_nxt   = '0;
            ucnt_nxt  = '0;
            fam_nxt   = FAM_SEC;
            phase_nxt = PH_WHOLE;
          end else begin
            err_nxt = 1'b1;
          end
        end
        PH_WHOLE, PH_DOT, PH_FRAC, PH_GAP: begin
          if (is_dig && phase_r == PH_WHOLE) begin
            whole_nxt = (w10 > {4'b0, WHOLE_CAP}) ? WHOLE_CAP : w10[WHOLE_W-1:0];
          end else if (is_dig && (phase_r == PH_DOT || phase_r == PH_FRAC)) begin
            if (cnt_r < 4'(FracDigits)) begin
              if (cnt_r < 4'd3) begin
                q_nxt = q_r + Q_W'(dig) * Q_W'(pow10(4'd2 - cnt_r));
              end else begin
                tail_nxt = tail_r + RW'(dig) * RW'(pow10(widx));
              end
              cnt_nxt = cnt_r + 4'd1;
            end
            phase_nxt = PH_FRAC;
          end else if (in_char_code == "." && phase_r == PH_WHOLE) begin
            phase_nxt = PH_DOT;
          end else if (is_ws && (phase_r == PH_WHOLE || phase_r == PH_FRAC)) begin
            phase_nxt = PH_GAP;
          end else if (is_ws && phase_r == PH_GAP) begin
            phase_nxt = PH_GAP;
          end else if (is_let && phase_r != PH_DOT) begin
            ucnt_nxt  = 3'd1;
            phase_nxt = PH_UNIT;
            case (lc)
              "s":     fam_nxt = FAM_SEC;
              "m":     fam_nxt = FAM_MIN;
              "h":     fam_nxt = FAM_HOUR;
              "d":     fam_nxt = FAM_DAY;
              default: begin
                err_nxt   = 1'b1;
                ucnt_nxt  = ucnt_r;
                phase_nxt = phase_r;
              end
            endcase
          end else begin
            err_nxt = 1'b1;
          end
        end
        PH_UNIT: begin
          if (is_let) begin
            if (ucnt_r == 3'd0) begin
              err_nxt = 1'b1;
            end else if (ucnt_r < unit_len(fam_r) && lc == unit_char(fam_r, ucnt_r)) begin
              ucnt_nxt = ucnt_r + 3'd1;
            end else if ((fam_r == FAM_SEC || fam_r == FAM_MIN) && ucnt_r == 3'd3
                         && lc == "s") begin
              ucnt_nxt = 3'd0;
            end else begin
              err_nxt = 1'b1;
            end
          end else if (is_ws && accepts(fam_r, ucnt_r)) begin
            commit_feed = 1'b1;
            phase_nxt   = PH_SEP;
          end else begin
            err_nxt = 1'b1;
          end
        end
        default: err_nxt = 1'b1;
      endcase
    end

    unit_ok = (phase_nxt == PH_UNIT) && accepts(fam_nxt, ucnt_nxt);
    ok_end  = !err_nxt && ((phase_nxt == PH_SEP) || unit_ok);

    tok_ctl_nxt.valid  = take;
    tok_ctl_nxt.commit = commit_feed || (in_last_char && ok_end && phase_nxt == PH_UNIT);
    tok_ctl_nxt.done   = in_last_char;
    tok_ctl_nxt.ok     = ok_end;
    tok_ctl_nxt.neg    = neg_nxt;
    tok_ctl_nxt.fam    = fam_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_LEAD;
      fam_r     <= FAM_SEC;
      ucnt_r    <= '0;
      neg_r     <= 1'b0;
      err_r     <= 1'b0;
      whole_r   <= '0;
      q_r       <= '0;
      tail_r    <= '0;
      cnt_r     <= '0;
      tok_ctl_r <= '0;
    end else if (adv) begin
      tok_ctl_r <= tok_ctl_nxt;
      if (take) begin
        if (in_last_char) begin
          phase_r <= PH_LEAD;
          fam_r   <= FAM_SEC;
          ucnt_r  <= '0;
          neg_r   <= 1'b0;
          err_r   <= 1'b0;
          whole_r <= '0;
          q_r     <= '0;
          tail_r  <= '0;
          cnt_r   <= '0;
        end else begin
          phase_r <= phase_nxt;
          fam_r   <= fam_nxt;
          ucnt_r  <= ucnt_nxt;
          neg_r   <= neg_nxt;
          err_r   <= err_nxt;
          whole_r <= whole_nxt;
          q_r     <= q_nxt;
          tail_r  <= tail_nxt;
          cnt_r   <= cnt_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && take) begin
      tok_whole_r <= whole_nxt;
      tok_q_r     <= q_nxt;
      tok_tail_r  <= tail_nxt;
    end
  end

endmodule

// ===== rtl/core/dttm_part.sv =====
// Part value pipeline: whole and fraction times unit, saturated, four stages.
module dttm_part
  import dttm_pkg::*;
#(
  parameter int FracDigits = FRAC_DIGITS,
  parameter int RW = tail_width(FRAC_DIGITS)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  tok_ctl_t           tok_ctl,
  input  logic [WHOLE_W-1:0] tok_whole,
  input  logic [Q_W-1:0]     tok_q,
  input  logic [RW-1:0]      tok_tail,
  output tok_ctl_t           part_ctl_r,
  output logic [62:0]        part_r
);

  localparam int S = magic_shift(FracDigits);
  localparam int PW = RW + C_W + 1;
  localparam logic [C_W-1:0] MAGIC_S = magic_c(1, FracDigits);
  localparam logic [C_W-1:0] MAGIC_M = magic_c(60, FracDigits);
  localparam logic [C_W-1:0] MAGIC_H = magic_c(3600, FracDigits);
  localparam logic [C_W-1:0] MAGIC_D = magic_c(86400, FracDigits);

  tok_ctl_t                 ctl1_r, ctl2_r, ctl3_r;
  logic [2*HALF_W-1:0]      pw_hi1_r, pw_lo1_r;
  logic [Q_W-1:0]           q1_r, q2_r;
  logic [RW-1:0]            tail1_r;
  logic [62:0]              wsat2_r, wsat3_r;
  logic [RW+C_LO_W-1:0]     pr_hi2_r, pr_lo2_r;
  logic [M_W-1:0]           qk3_r;
  logic [Y_W-1:0]           y3_r;

  logic [M_W-1:0]           m1;
  logic [C_W-1:0]           magic;
  logic [HALF_W+2*HALF_W:0] wprod;
  logic [PW-1:0]            prod;
  logic [63:0]              psum;

  assign m1 = unit_ms(tok_ctl.fam);

  always_comb begin
    case (ctl1_r.fam)
      FAM_SEC:  magic = MAGIC_S;
      FAM_MIN:  magic = MAGIC_M;
      FAM_HOUR: magic = MAGIC_H;
      default:  magic = MAGIC_D;
    endcase
  end

  assign wprod = ({(HALF_W+1)'(0), pw_hi1_r} << HALF_W) + (3*HALF_W+1)'(pw_lo1_r);
  assign prod  = (PW'(pr_hi2_r) << C_LO_W) + PW'(pr_lo2_r);
  assign psum  = {1'b0, wsat3_r} + 64'(qk3_r) + 64'(y3_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r     <= '0;
      ctl2_r     <= '0;
      ctl3_r     <= '0;
      part_ctl_r <= '0;
    end else if (adv) begin
      ctl1_r     <= tok_ctl;
      ctl2_r     <= ctl1_r;
      ctl3_r     <= ctl2_r;
      part_ctl_r <= ctl3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1: whole amount split in halves times milliseconds per unit
      pw_hi1_r <= tok_whole[WHOLE_W-1:HALF_W] * m1;
      pw_lo1_r <= tok_whole[HALF_W-1:0] * m1;
      q1_r     <= tok_q;
      tail1_r  <= tok_tail;
      // stage 2: saturate whole term; tail digits times reciprocal
      wsat2_r  <= (wprod > (3*HALF_W+1)'(SAT_LIMIT)) ? SAT_LIMIT[62:0] : wprod[62:0];
      pr_hi2_r <= tail1_r * magic[C_W-1:C_LO_W];
      pr_lo2_r <= tail1_r * magic[C_LO_W-1:0];
      q2_r     <= q1_r;
      // stage 3: thousandths times seconds, tail quotient
      wsat3_r  <= wsat2_r;
      qk3_r    <= M_W'(q2_r) * M_W'(unit_sec(ctl2_r.fam));
      y3_r     <= Y_W'(prod >> S);
      // stage 4: saturated part total
      part_r   <= (psum > SAT_LIMIT) ? SAT_LIMIT[62:0] : psum[62:0];
    end
  end

endmodule

// ===== rtl/core/dttm_acc.sv =====
// Running total per text and the result register.
module dttm_acc
  import dttm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  tok_ctl_t           part_ctl,
  input  logic [62:0]        part,
  output logic               out_valid_r,
  output logic               out_parse_ok_r,
  output logic signed [63:0] out_span_msec_r
);

  logic [63:0] total_r;
  logic [63:0] sum;
  logic [63:0] sum_sat;

  assign sum     = total_r + (part_ctl.commit ? {1'b0, part} : 64'd0);
  assign sum_sat = (sum > SAT_LIMIT) ? SAT_LIMIT : sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= part_ctl.valid && part_ctl.done;
      if (part_ctl.valid) begin
        total_r <= part_ctl.done ? 64'd0 : sum_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && part_ctl.valid && part_ctl.done) begin
      out_parse_ok_r  <= part_ctl.ok;
      out_span_msec_r <= !part_ctl.ok ? 64'sd0 :
                         part_ctl.neg ? -$signed(sum_sat) : $signed(sum_sat);
    end
  end

endmodule

// ===== rtl/core/duration_text_to_milliseconds_top.sv =====
// Top level of the duration text parser: scanner, part pipeline, total.
// A result passes the scanner token, the part stages and the result register.
// Throughput: one character per cycle; the scanner, the four-stage part
//   pipeline and the total all advance together while the result is not held.
// in_stall is high only while a result sits in the output register and is stalled.
// Reset (rst_n low, synchronous) empties the pipeline and clears the scanner.
module duration_text_to_milliseconds_top
  import dttm_pkg::*;
#(
  parameter int FracDigits = FRAC_DIGITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_char_code,
  input  logic               in_last_char,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_parse_ok,
  output logic signed [63:0] out_span_msec
);

  localparam int RW = tail_width(FracDigits);

  // Whole design moves on one enable: everything steps unless a result is held.
  logic               adv;
  tok_ctl_t           scan_ctl;
  logic [WHOLE_W-1:0] scan_whole;
  logic [Q_W-1:0]     scan_q;
  logic [RW-1:0]      scan_tail;
  tok_ctl_t           part_ctl;
  logic [62:0]        part;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Grammar and digit capture, one character per item.
  dttm_scan #(
    .FracDigits(FracDigits),
    .RW        (RW)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_valid    (in_valid),
    .in_char_code(in_char_code),
    .in_last_char(in_last_char),
    .tok_ctl_r   (scan_ctl),
    .tok_whole_r (scan_whole),
    .tok_q_r     (scan_q),
    .tok_tail_r  (scan_tail)
  );

  // Part value in milliseconds: exact fixed point, truncated, saturated.
  dttm_part #(
    .FracDigits(FracDigits),
    .RW        (RW)
  ) u_part (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .tok_ctl   (scan_ctl),
    .tok_whole (scan_whole),
    .tok_q     (scan_q),
    .tok_tail  (scan_tail),
    .part_ctl_r(part_ctl),
    .part_r    (part)
  );

  // Saturating total and the result register.
  dttm_acc u_acc (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .part_ctl       (part_ctl),
    .part           (part),
    .out_valid_r    (out_valid),
    .out_parse_ok_r (out_parse_ok),
    .out_span_msec_r(out_span_msec)
  );

  // A failed parse always reports zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_parse_ok |-> out_span_msec == 64'sd0)
    else $error("nonzero span on failed parse");

  // Saturation keeps the result off the most negative code.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_span_msec != 64'sh8000_0000_0000_0000)
    else $error("span outside saturation range");

  // A part is committed at text end only when the text parsed.
  assert property (@(posedge clk) disable iff (!rst_n)
    scan_ctl.valid && scan_ctl.commit && scan_ctl.done |-> scan_ctl.ok)
    else $error("commit on failed text end");

endmodule
